FILE: rtl/bqrc_pkg.sv
// Shared constants, codes and a helper function of the broadcast queue.
package bqrc_pkg;

    // Defaults of the top-level parameters
    localparam int SLOTS_DEF     = 16;
    localparam int READERS_DEF   = 4;
    localparam int WORD_BITS_DEF = 32;
    localparam int MAX_READERS   = 16;

    // Fixed field widths
    localparam int ID_BITS     = 32;
    localparam int OPCODE_BITS = 2;
    localparam int READER_BITS = 2;
    localparam int STATUS_BITS = 3;
    localparam int SUBS_BITS   = 3;
    localparam int USED_BITS   = 5;
    localparam int APB_DATA    = 32;
    localparam int APB_ADDR    = 2;

    // Register word index
    localparam logic [APB_ADDR-1:0] REG_SUBSCRIBER_MASK = 2'd0;

    // Operation codes
    localparam logic [OPCODE_BITS-1:0] OP_SEND  = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_PUT   = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_NO_SUB   = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_NOT_SUB  = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_NOTHING  = 3'd4;

    // Sequencer states
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MIN   = 10'b00_0000_0010,
        ST_RECL  = 10'b00_0000_0100,
        ST_APP   = 10'b00_0000_1000,
        ST_CURRD = 10'b00_0001_0000,
        ST_CUR   = 10'b00_0010_0000,
        ST_SRCH  = 10'b00_0100_0000,
        ST_PAYRD = 10'b00_1000_0000,
        ST_PAY   = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

    // Count the set bits of a reader mask
    function automatic logic [4:0] popcount(input logic [MAX_READERS-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < MAX_READERS; i++) begin
            n = n + {4'd0, v[i]};
        end
        return n;
    endfunction

endpackage

FILE: rtl/broadcast_queue_with_reader_cursors_top.sv
// Broadcast message queue with per-reader cursors, built around slot memories.
// Steps: a send with subscribers or a put runs the reader minimum pass, the slot
// reclaim scan and the append; a query from a subscriber runs the slot search
// scan; other items go straight to the result. The queue takes one item at a
// time and is not ready again until its sequencer is idle. A subscription
// change runs the reader minimum pass and the slot reclaim scan.
// Reset: synchronous, active low; clears valid bits, cursors, ids and the mask.
module broadcast_queue_with_reader_cursors_top
    import bqrc_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int READERS   = READERS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OPCODE_BITS-1:0] s_opcode,
    input  logic [READER_BITS-1:0] s_reader,
    input  logic [WORD_BITS-1:0]   s_payload,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_BITS-1:0] m_status,
    output logic [WORD_BITS-1:0]   m_message,
    output logic                   m_has_new,
    output logic [SUBS_BITS-1:0]   m_subscribers,
    output logic [USED_BITS-1:0]   m_entries_used,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR-1:0]    paddr,
    input  logic [APB_DATA-1:0]    pwdata,
    output logic [APB_DATA-1:0]    prdata,
    output logic                   pready
);

    localparam int SW = $clog2(SLOTS);
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CW = $clog2(READERS + 1);
    localparam int UW = $clog2(SLOTS + 1);
    localparam logic [SW:0]   SLOT_CNT  = (SW + 1)'(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [RW-1:0] LAST_RDR  = RW'(READERS - 1);

    // Control state
    state_t                  state_reg, state_next;
    logic [READERS-1:0]      mask_reg, mask_next;
    logic [CW-1:0]           subs_reg, subs_next;
    logic [UW-1:0]           used_reg, used_next;
    logic [ID_BITS-1:0]      idgen_reg, idgen_next;
    logic [ID_BITS-1:0]      last_id_reg [READERS];
    logic [ID_BITS-1:0]      last_id_next [READERS];
    logic [READERS-1:0]      on_reg, on_next;
    logic [SW-1:0]           rslot_reg [READERS];
    logic [SW-1:0]           rslot_next [READERS];
    logic [SLOTS-1:0]        valid_reg, valid_next;
    logic                    cfg_run_reg, cfg_run_next;
    logic [RW-1:0]           min_idx_reg, min_idx_next;
    logic [SW:0]             iss_reg, iss_next;
    logic                    pipe_vld_reg, pipe_vld_next;
    logic                    m_valid_reg, m_valid_next;

    // Working and payload registers
    logic [READER_BITS-1:0]  rdr_reg, rdr_next;
    logic [WORD_BITS-1:0]    pay_reg, pay_next;
    logic [ID_BITS-1:0]      lowest_reg, lowest_next;
    logic [SW-1:0]           pipe_idx_reg, pipe_idx_next;
    logic                    free_ok_reg, free_ok_next;
    logic [SW-1:0]           free_slot_reg, free_slot_next;
    logic [ID_BITS-1:0]      bound_reg, bound_next;
    logic                    best_ok_reg, best_ok_next;
    logic [SW-1:0]           best_slot_reg, best_slot_next;
    logic [ID_BITS-1:0]      best_id_reg, best_id_next;
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    logic [WORD_BITS-1:0]    msg_reg, msg_next;
    logic [STATUS_BITS-1:0]  m_status_reg, m_status_next;
    logic [WORD_BITS-1:0]    m_message_reg, m_message_next;
    logic                    m_has_new_reg, m_has_new_next;
    logic [SUBS_BITS-1:0]    m_subs_reg, m_subs_next;
    logic [USED_BITS-1:0]    m_used_reg, m_used_next;

    // Slot memories
    logic [ID_BITS-1:0]      mem_id  [SLOTS];
    logic [WORD_BITS-1:0]    mem_pay [SLOTS];
    logic [CW-1:0]           mem_cnt [SLOTS];
    logic [SW-1:0]           rd_addr;
    logic [ID_BITS-1:0]      id_q;
    logic [WORD_BITS-1:0]    pay_q;
    logic [CW-1:0]           cnt_q;
    logic                    app_we;
    logic                    cnt_we;
    logic [SW-1:0]           cnt_wa;
    logic [CW-1:0]           cnt_wd;

    // Reader table read port
    logic [RW-1:0]           rd_ridx;
    logic [ID_BITS-1:0]      rd_last_id;
    logic [SW-1:0]           rd_rslot;

    logic                    cfg_wr;
    logic [READERS-1:0]      cfg_mask;
    logic                    in_fire;
    logic                    in_sub;
    logic                    cur_sub;

    assign pready   = 1'b1;
    assign prdata   = APB_DATA'(mask_reg);
    assign cfg_wr   = psel && penable && pwrite && (paddr == REG_SUBSCRIBER_MASK);
    assign cfg_mask = pwdata[READERS-1:0];

    assign s_ready  = (state_reg == ST_IDLE) && !cfg_wr;
    assign in_fire  = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_message      = m_message_reg;
    assign m_has_new      = m_has_new_reg;
    assign m_subscribers  = m_subs_reg;
    assign m_entries_used = m_used_reg;

    // Select the reader whose table entry is read this cycle
    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_ridx = RW'(s_reader);
        end else if (state_reg == ST_MIN) begin
            rd_ridx = min_idx_reg;
        end else begin
            rd_ridx = RW'(rdr_reg);
        end
    end

    assign rd_last_id = last_id_reg[rd_ridx];
    assign rd_rslot   = rslot_reg[rd_ridx];
    assign in_sub  = (32'(s_reader) < READERS) && mask_reg[RW'(s_reader)];
    assign cur_sub = (32'(rdr_reg) < READERS) && mask_reg[RW'(rdr_reg)];

    // Choose the memory read address
    always_comb begin
        if (state_reg == ST_CURRD) begin
            rd_addr = rd_rslot;
        end else if (state_reg == ST_PAYRD) begin
            rd_addr = best_slot_reg;
        end else begin
            rd_addr = iss_reg[SW-1:0];
        end
    end

    // Slot memories: one write port each, registered read
    always_ff @(posedge aclk) begin
        if (app_we) begin
            mem_id[free_slot_reg]  <= idgen_next;
            mem_pay[free_slot_reg] <= pay_reg;
        end
        if (cnt_we) begin
            mem_cnt[cnt_wa] <= cnt_wd;
        end
        id_q  <= mem_id[rd_addr];
        pay_q <= mem_pay[rd_addr];
        cnt_q <= mem_cnt[rd_addr];
    end

    // Sequencer and next-state logic
    always_comb begin
        logic fr;
        logic last;
        logic was;
        logic now;

        state_next     = state_reg;
        mask_next      = mask_reg;
        subs_next      = subs_reg;
        used_next      = used_reg;
        idgen_next     = idgen_reg;
        last_id_next   = last_id_reg;
        on_next        = on_reg;
        rslot_next     = rslot_reg;
        valid_next     = valid_reg;
        cfg_run_next   = cfg_run_reg;
        min_idx_next   = min_idx_reg;
        iss_next       = iss_reg;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = pipe_idx_reg;
        rdr_next       = rdr_reg;
        pay_next       = pay_reg;
        lowest_next    = lowest_reg;
        free_ok_next   = free_ok_reg;
        free_slot_next = free_slot_reg;
        bound_next     = bound_reg;
        best_ok_next   = best_ok_reg;
        best_slot_next = best_slot_reg;
        best_id_next   = best_id_reg;
        status_next    = status_reg;
        msg_next       = msg_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_message_next = m_message_reg;
        m_has_new_next = m_has_new_reg;
        m_subs_next    = m_subs_reg;
        m_used_next    = m_used_reg;
        app_we         = 1'b0;
        cnt_we         = 1'b0;
        cnt_wa         = rd_rslot;
        cnt_wd         = '0;
        fr             = 1'b0;
        last           = pipe_vld_reg && (pipe_idx_reg == LAST_SLOT);
        was            = 1'b0;
        now            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_wr && (cfg_mask != mask_reg)) begin
                    // Apply subscription changes, then reclaim
                    for (int r = 0; r < READERS; r++) begin
                        was = mask_reg[r];
                        now = cfg_mask[r];
                        if (was != now) begin
                            on_next[r]      = 1'b0;
                            rslot_next[r]   = '0;
                            last_id_next[r] = now ? idgen_reg : '0;
                        end
                    end
                    mask_next    = cfg_mask;
                    subs_next    = CW'(popcount(MAX_READERS'(cfg_mask)));
                    cfg_run_next = 1'b1;
                    min_idx_next = '0;
                    lowest_next  = '1;
                    state_next   = ST_MIN;
                end else if (in_fire) begin
                    rdr_next     = s_reader;
                    pay_next     = s_payload;
                    msg_next     = '0;
                    status_next  = STAT_OK;
                    cfg_run_next = 1'b0;
                    min_idx_next = '0;
                    lowest_next  = '1;
                    iss_next     = '0;
                    best_ok_next = 1'b0;
                    unique case (s_opcode)
                        OP_SEND: begin
                            if (mask_reg == '0) begin
                                status_next = STAT_NO_SUB;
                                state_next  = ST_DONE;
                            end else begin
                                state_next  = ST_MIN;
                            end
                        end
                        OP_PUT: begin
                            state_next = ST_MIN;
                        end
                        OP_QUERY: begin
                            if (!in_sub) begin
                                status_next = STAT_NOT_SUB;
                                state_next  = ST_DONE;
                            end else if (on_reg[RW'(s_reader)]) begin
                                state_next  = ST_CURRD;
                            end else begin
                                bound_next  = rd_last_id;
                                state_next  = ST_SRCH;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_MIN: begin
                // Find the lowest last id over subscribed readers
                if (mask_reg[min_idx_reg] && (rd_last_id < lowest_reg)) begin
                    lowest_next = rd_last_id;
                end
                min_idx_next = min_idx_reg + 1'b1;
                if (min_idx_reg == LAST_RDR) begin
                    iss_next     = '0;
                    free_ok_next = 1'b0;
                    state_next   = ST_RECL;
                end
            end

            ST_RECL: begin
                // Issue one slot read per cycle
                if (iss_reg < SLOT_CNT) begin
                    iss_next      = iss_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = iss_reg[SW-1:0];
                end
                // Free fully read old messages; note the lowest free slot
                if (pipe_vld_reg) begin
                    fr = valid_reg[pipe_idx_reg] && (id_q < lowest_reg) &&
                         (cnt_q == subs_reg);
                    if (fr) begin
                        valid_next[pipe_idx_reg] = 1'b0;
                        used_next = used_next - 1'b1;
                    end
                    if ((!valid_reg[pipe_idx_reg] || fr) && !free_ok_reg) begin
                        free_ok_next   = 1'b1;
                        free_slot_next = pipe_idx_reg;
                    end
                end
                if (last) begin
                    pipe_vld_next = 1'b0;
                    state_next    = cfg_run_reg ? ST_IDLE : ST_APP;
                end
            end

            ST_APP: begin
                // Store the message in the lowest free slot, or report the store full
                if (free_ok_reg) begin
                    idgen_next                = idgen_reg + 1'b1;
                    valid_next[free_slot_reg] = 1'b1;
                    used_next                 = used_reg + 1'b1;
                    app_we                    = 1'b1;
                    cnt_we                    = 1'b1;
                    cnt_wa                    = free_slot_reg;
                    cnt_wd                    = '0;
                end else begin
                    status_next = STAT_FULL;
                end
                state_next = ST_DONE;
            end

            ST_CURRD: begin
                state_next = ST_CUR;
            end

            ST_CUR: begin
                // Count the current message as read, search past its id
                cnt_we     = 1'b1;
                cnt_wa     = rd_rslot;
                cnt_wd     = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
                bound_next = id_q;
                iss_next   = '0;
                state_next = ST_SRCH;
            end

            ST_SRCH: begin
                if (iss_reg < SLOT_CNT) begin
                    iss_next      = iss_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = iss_reg[SW-1:0];
                end
                // Keep the smallest id above the bound
                if (pipe_vld_reg && valid_reg[pipe_idx_reg] && (id_q > bound_reg) &&
                    (!best_ok_reg || (id_q < best_id_reg))) begin
                    best_ok_next   = 1'b1;
                    best_slot_next = pipe_idx_reg;
                    best_id_next   = id_q;
                end
                if (last) begin
                    pipe_vld_next = 1'b0;
                    state_next    = ST_PAYRD;
                end
            end

            ST_PAYRD: begin
                if (best_ok_reg) begin
                    state_next = ST_PAY;
                end else begin
                    on_next[RW'(rdr_reg)]    = 1'b0;
                    rslot_next[RW'(rdr_reg)] = '0;
                    status_next              = STAT_NOTHING;
                    state_next               = ST_DONE;
                end
            end

            ST_PAY: begin
                // Move the cursor onto the found message
                on_next[RW'(rdr_reg)]      = 1'b1;
                rslot_next[RW'(rdr_reg)]   = best_slot_reg;
                last_id_next[RW'(rdr_reg)] = best_id_reg;
                msg_next                   = pay_q;
                state_next                 = ST_DONE;
            end

            ST_DONE: begin
                // Hand the transaction to the output register
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_message_next = msg_reg;
                    m_has_new_next = cur_sub && (rd_last_id < idgen_reg);
                    m_subs_next    = SUBS_BITS'(subs_reg);
                    m_used_next    = USED_BITS'(used_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '0;
            subs_reg     <= '0;
            used_reg     <= '0;
            idgen_reg    <= '0;
            on_reg       <= '0;
            valid_reg    <= '0;
            cfg_run_reg  <= 1'b0;
            min_idx_reg  <= '0;
            iss_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int r = 0; r < READERS; r++) begin
                last_id_reg[r] <= '0;
                rslot_reg[r]   <= '0;
            end
        end else begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            subs_reg     <= subs_next;
            used_reg     <= used_next;
            idgen_reg    <= idgen_next;
            on_reg       <= on_next;
            valid_reg    <= valid_next;
            cfg_run_reg  <= cfg_run_next;
            min_idx_reg  <= min_idx_next;
            iss_reg      <= iss_next;
            pipe_vld_reg <= pipe_vld_next;
            m_valid_reg  <= m_valid_next;
            last_id_reg  <= last_id_next;
            rslot_reg    <= rslot_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        rdr_reg       <= rdr_next;
        pay_reg       <= pay_next;
        lowest_reg    <= lowest_next;
        pipe_idx_reg  <= pipe_idx_next;
        free_ok_reg   <= free_ok_next;
        free_slot_reg <= free_slot_next;
        bound_reg     <= bound_next;
        best_ok_reg   <= best_ok_next;
        best_slot_reg <= best_slot_next;
        best_id_reg   <= best_id_next;
        status_reg    <= status_next;
        msg_reg       <= msg_next;
        m_status_reg  <= m_status_next;
        m_message_reg <= m_message_next;
        m_has_new_reg <= m_has_new_next;
        m_subs_reg    <= m_subs_next;
        m_used_reg    <= m_used_next;
    end

endmodule

FILE: tb/broadcast_queue_with_reader_cursors_top_tb.sv
// Self-checking testbench for the broadcast queue with reader cursors.
`timescale 1ns / 100ps

module broadcast_queue_with_reader_cursors_top_tb
    import bqrc_pkg::*;
();

    localparam int NSLOT = SLOTS_DEF;
    localparam int NRDR = READERS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [31:0]            message;
        logic                   has_new;
        logic [SUBS_BITS-1:0]   subscribers;
        logic [USED_BITS-1:0]   entries_used;
    } reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OPCODE_BITS-1:0] s_opcode = '0;
    logic [READER_BITS-1:0] s_reader = '0;
    logic [31:0] s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_BITS-1:0] m_status;
    logic [31:0] m_message;
    logic m_has_new;
    logic [SUBS_BITS-1:0] m_subscribers;
    logic [USED_BITS-1:0] m_entries_used;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR-1:0] paddr = '0;
    logic [APB_DATA-1:0] pwdata = '0;
    logic [APB_DATA-1:0] prdata;
    logic pready;

    // Mirror of the queue state
    logic        q_valid [NSLOT];
    logic [31:0] q_id [NSLOT];
    logic [31:0] q_payload [NSLOT];
    int          q_reads [NSLOT];
    logic [31:0] q_id_gen;
    logic [31:0] q_last_id [NRDR];
    logic        q_on_slot [NRDR];
    int          q_slot [NRDR];
    logic [3:0]  q_mask;

    reply_t expected_replies [$];
    int errors = 0;
    int cycles = 0;
    int next_gap = 1;
    int hold_cycles = 0;
    bit quiet = 0;

    broadcast_queue_with_reader_cursors_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_reader(s_reader), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_message(m_message), .m_has_new(m_has_new),
        .m_subscribers(m_subscribers), .m_entries_used(m_entries_used),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int subscriber_count();
        int n;
        n = 0;
        for (int r = 0; r < NRDR; r++) n += int'(q_mask[r]);
        return n;
    endfunction

    function automatic int used_count();
        int n;
        n = 0;
        for (int s = 0; s < NSLOT; s++) n += int'(q_valid[s]);
        return n;
    endfunction

    // Free messages older than every cursor and read by every subscriber
    function automatic void reclaim_slots();
        logic [31:0] lowest;
        int subs;
        lowest = 32'hFFFF_FFFF;
        subs = subscriber_count();
        for (int r = 0; r < NRDR; r++)
            if (q_mask[r] && q_last_id[r] < lowest) lowest = q_last_id[r];
        for (int s = 0; s < NSLOT; s++)
            if (q_valid[s] && q_id[s] < lowest && q_reads[s] == subs) q_valid[s] = 1'b0;
    endfunction

    function automatic bit append_message(input logic [31:0] word);
        reclaim_slots();
        for (int s = 0; s < NSLOT; s++) begin
            if (!q_valid[s]) begin
                q_id_gen = q_id_gen + 1;
                q_valid[s] = 1'b1;
                q_id[s] = q_id_gen;
                q_payload[s] = word;
                q_reads[s] = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int next_newer(input logic [31:0] bound);
        int best;
        best = -1;
        for (int s = 0; s < NSLOT; s++)
            if (q_valid[s] && q_id[s] > bound && (best < 0 || q_id[s] < q_id[best])) best = s;
        return best;
    endfunction

    function automatic void apply_mask(input logic [3:0] mask);
        if (mask == q_mask) return;
        for (int r = 0; r < NRDR; r++) begin
            if (mask[r] != q_mask[r]) begin
                q_on_slot[r] = 1'b0;
                q_slot[r] = 0;
                q_last_id[r] = mask[r] ? q_id_gen : 32'd0;
            end
        end
        q_mask = mask;
        reclaim_slots();
    endfunction

    // Work out the reply of one transaction and queue it
    function automatic void predict_reply(input logic [1:0] op, input logic [1:0] rd,
                                          input logic [31:0] word);
        reply_t rep;
        bit subscribed;
        int found;
        int cur;
        subscribed = q_mask[rd];
        rep.status = STAT_OK;
        rep.message = '0;
        if (op == OP_SEND) begin
            if (q_mask == 0) rep.status = STAT_NO_SUB;
            else if (!append_message(word)) rep.status = STAT_FULL;
        end else if (op == OP_PUT) begin
            if (!append_message(word)) rep.status = STAT_FULL;
        end else if (op == OP_QUERY) begin
            if (!subscribed) begin
                rep.status = STAT_NOT_SUB;
            end else begin
                if (q_on_slot[rd]) begin
                    cur = q_slot[rd];
                    if (q_reads[cur] < 255) q_reads[cur]++;
                    found = next_newer(q_id[cur]);
                end else begin
                    found = next_newer(q_last_id[rd]);
                end
                if (found >= 0) begin
                    q_on_slot[rd] = 1'b1;
                    q_slot[rd] = found;
                    q_last_id[rd] = q_id[found];
                    rep.message = q_payload[found];
                end else begin
                    q_on_slot[rd] = 1'b0;
                    q_slot[rd] = 0;
                    rep.status = STAT_NOTHING;
                end
            end
        end
        rep.has_new = subscribed && (q_last_id[rd] < q_id_gen);
        rep.subscribers = SUBS_BITS'(subscriber_count());
        rep.entries_used = USED_BITS'(used_count());
        expected_replies.push_back(rep);
    endfunction

    // Offer one transaction and wait for it to be taken
    task automatic send_item(input logic [1:0] op, input logic [1:0] rd, input logic [31:0] word);
        repeat (next_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_reader <= rd;
        s_payload <= word;
        do @(posedge aclk); while (!s_ready);
        predict_reply(op, rd, word);
        next_gap = quiet ? 0 : $urandom_range(0, 16);
        if (next_gap != 0) s_valid <= 1'b0;
    endtask

    // Stop offering and wait until every reply is back
    task automatic drain();
        if (next_gap == 0) s_valid <= 1'b0;
        next_gap = 1;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [3:0] mask);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_SUBSCRIBER_MASK;
        pwdata <= APB_DATA'(mask);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_mask(mask);
        // let the subscription reclaim pass finish
        repeat (NRDR + NSLOT + 8) @(posedge aclk);
    endtask

    // Check every reply against the oldest prediction
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                report("unexpected reply", {29'd0, m_status}, 32'd0);
            end else begin
                want = expected_replies.pop_front();
                if (m_status !== want.status)
                    report("status", 32'(m_status), 32'(want.status));
                if (m_message !== want.message) report("message", m_message, want.message);
                if (m_has_new !== want.has_new)
                    report("has_new", 32'(m_has_new), 32'(want.has_new));
                if (m_subscribers !== want.subscribers)
                    report("subscribers", 32'(m_subscribers), 32'(want.subscribers));
                if (m_entries_used !== want.entries_used)
                    report("entries_used", 32'(m_entries_used), 32'(want.entries_used));
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic test_no_subscribers();
        send_item(OP_SEND, 2'd0, 32'hFFFF_FFFF);
        send_item(OP_PUT, 2'd3, 32'h0000_0000);
        send_item(OP_PUT, 2'd1, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 2'd2, 32'h1234_5678);
        send_item(OP_UNUSED, 2'd3, 32'hFFFF_FFFF);
    endtask

    task automatic test_cursor_walk();
        write_mask(4'hF);
        send_item(OP_SEND, 2'd0, 32'hA5A5_A5A5);
        send_item(OP_PUT, 2'd1, 32'h5A5A_5A5A);
        for (int r = 0; r < NRDR; r++)
            for (int k = 0; k < 3; k++) send_item(OP_QUERY, 2'(r), 32'd0);
        send_item(OP_SEND, 2'd2, 32'h0000_0001);
    endtask

    task automatic test_full_store();
        write_mask(4'h8);
        for (int i = 0; i < NSLOT + 2; i++) send_item(OP_PUT, 2'd3, $urandom());
        send_item(OP_SEND, 2'd3, 32'hDEAD_BEEF);
        write_mask(4'h0);
        send_item(OP_QUERY, 2'd3, 32'd0);
    endtask

    task automatic test_backpressure();
        write_mask(4'h3);
        drain();
        hold_cycles = 400;
        for (int i = 0; i < 24; i++)
            send_item((i % 3 == 2) ? OP_QUERY : OP_PUT, 2'($urandom_range(0, 1)), $urandom());
    endtask

    task automatic test_random_traffic();
        logic [3:0] masks [12];
        int pick;
        masks = '{4'hF, 4'h1, 4'h0, 4'h8, 4'h5, 4'hF, 4'hA, 4'h3, 4'hE, 4'h0, 4'h6, 4'hF};
        for (int p = 0; p < 12; p++) begin
            write_mask((p % 4 == 3) ? 4'($urandom_range(0, 15)) : masks[p]);
            quiet = (p % 5 == 2);
            for (int i = 0; i < 90; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 38)
                    send_item(pick[0] ? OP_SEND : OP_PUT, 2'($urandom_range(0, 3)), $urandom());
                else if (pick < 96)
                    send_item(OP_QUERY, 2'($urandom_range(0, 3)), $urandom());
                else
                    send_item(OP_UNUSED, 2'($urandom_range(0, 3)), $urandom());
            end
            quiet = 0;
        end
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            q_valid[s] = 1'b0;
            q_id[s] = '0;
            q_payload[s] = '0;
            q_reads[s] = 0;
        end
        for (int r = 0; r < NRDR; r++) begin
            q_last_id[r] = '0;
            q_on_slot[r] = 1'b0;
            q_slot[r] = 0;
        end
        q_id_gen = '0;
        q_mask = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (NRDR + NSLOT + 4) @(posedge aclk);

        test_no_subscribers();
        test_cursor_walk();
        test_full_store();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
